@@ rtl/gdb_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, constants and calendar tables of the Gregorian day-distance block.
package gdb_pkg;

  localparam int unsigned YEAR_W  = 14;
  localparam int unsigned MONTH_W = 4;
  localparam int unsigned DAY_W   = 5;
  localparam int unsigned DAYS_W  = 22;
  // A day number of a 14-bit year stays below 2**23.
  localparam int unsigned DNUM_W  = 23;
  // Width of a year divided by one hundred.
  localparam int unsigned Q_W     = 8;
  localparam int unsigned MLEN_W  = 5;
  localparam int unsigned DBM_W   = 9;

  localparam int unsigned DEFAULT_MAX_YEAR = 9999;

  // floor(x / 100) == (x * 5243) >> 19 for every x below 2**14.
  localparam int unsigned RECIP_100   = 5243;
  localparam int unsigned RECIP_SHIFT = 19;
  localparam int unsigned PROD_W      = YEAR_W + 13;
  localparam int unsigned CENTURY     = 100;
  localparam int unsigned DAYS_PER_YEAR = 365;

  localparam logic [DAYS_W-1:0] DAYS_MAX = {DAYS_W{1'b1}};

  localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
  localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
  localparam logic [MONTH_W-1:0] MONTH_MAR = 4'd3;
  localparam logic [MONTH_W-1:0] MONTH_APR = 4'd4;
  localparam logic [MONTH_W-1:0] MONTH_MAY = 4'd5;
  localparam logic [MONTH_W-1:0] MONTH_JUN = 4'd6;
  localparam logic [MONTH_W-1:0] MONTH_JUL = 4'd7;
  localparam logic [MONTH_W-1:0] MONTH_AUG = 4'd8;
  localparam logic [MONTH_W-1:0] MONTH_SEP = 4'd9;
  localparam logic [MONTH_W-1:0] MONTH_OCT = 4'd10;
  localparam logic [MONTH_W-1:0] MONTH_NOV = 4'd11;
  localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

  typedef struct packed {
    logic [YEAR_W-1:0]  first_year;
    logic [MONTH_W-1:0] first_month;
    logic [DAY_W-1:0]   first_day;
    logic [YEAR_W-1:0]  second_year;
    logic [MONTH_W-1:0] second_month;
    logic [DAY_W-1:0]   second_day;
  } req_t;

  typedef struct packed {
    logic [DAYS_W-1:0] days_apart;
    logic              both_valid;
  } res_t;

  // One date after the first stage.
  typedef struct packed {
    logic [YEAR_W-1:0]  year;
    logic [YEAR_W-1:0]  yprev;
    logic [DNUM_W-1:0]  yprev365;
    logic [Q_W-1:0]     qprev100;
    logic [Q_W-1:0]     qyear100;
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]   day;
    logic               year_ok;
  } front_t;

  // One date after the second stage.
  typedef struct packed {
    logic [DNUM_W-1:0] dnum;
    logic              ok;
  } dcount_t;

  // Days in the months before the given month of a common year.
  function automatic logic [DBM_W-1:0] days_before_month(input logic [MONTH_W-1:0] m);
    logic [DBM_W-1:0] r;
    case (m)
      MONTH_JAN: r = 9'd0;
      MONTH_FEB: r = 9'd31;
      MONTH_MAR: r = 9'd59;
      MONTH_APR: r = 9'd90;
      MONTH_MAY: r = 9'd120;
      MONTH_JUN: r = 9'd151;
      MONTH_JUL: r = 9'd181;
      MONTH_AUG: r = 9'd212;
      MONTH_SEP: r = 9'd243;
      MONTH_OCT: r = 9'd273;
      MONTH_NOV: r = 9'd304;
      MONTH_DEC: r = 9'd334;
      default:   r = 9'd0;
    endcase
    return r;
  endfunction

  // Length of a month; zero for a month code that names no month.
  function automatic logic [MLEN_W-1:0] month_length(input logic [MONTH_W-1:0] m,
                                                     input logic leap);
    logic [MLEN_W-1:0] r;
    case (m)
      MONTH_FEB: r = leap ? 5'd29 : 5'd28;
      MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: r = 5'd30;
      MONTH_JAN, MONTH_MAR, MONTH_MAY, MONTH_JUL,
      MONTH_AUG, MONTH_OCT, MONTH_DEC: r = 5'd31;
      default: r = 5'd0;
    endcase
    return r;
  endfunction

endpackage

@@ rtl/gdb_front.sv @@
`timescale 1ns / 1ps
// First stage: year range check and the constant multiplications for both dates.
module gdb_front #(
  parameter int unsigned MAX_YEAR = gdb_pkg::DEFAULT_MAX_YEAR
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   vld_i,
  input  gdb_pkg::req_t          req_i,
  output logic                   vld_o,
  output gdb_pkg::front_t [1:0]  front_o
);
  import gdb_pkg::*;

  logic [YEAR_W-1:0]  year  [2];
  logic [MONTH_W-1:0] month [2];
  logic [DAY_W-1:0]   day   [2];
  front_t [1:0]       front_d;
  front_t [1:0]       front_q;
  logic               vld_q;

  assign year[0]  = req_i.first_year;
  assign month[0] = req_i.first_month;
  assign day[0]   = req_i.first_day;
  assign year[1]  = req_i.second_year;
  assign month[1] = req_i.second_month;
  assign day[1]   = req_i.second_day;

  always_comb begin
    for (int i = 0; i < 2; i++) begin
      logic [YEAR_W-1:0] yp;
      logic [PROD_W-1:0] prod_y;
      logic [PROD_W-1:0] prod_p;
      yp     = year[i] - YEAR_W'(1);
      prod_y = PROD_W'(year[i]) * PROD_W'(RECIP_100);
      prod_p = PROD_W'(yp) * PROD_W'(RECIP_100);
      front_d[i].year     = year[i];
      front_d[i].yprev    = yp;
      front_d[i].yprev365 = DNUM_W'(yp) * DNUM_W'(DAYS_PER_YEAR);
      front_d[i].qyear100 = prod_y[RECIP_SHIFT +: Q_W];
      front_d[i].qprev100 = prod_p[RECIP_SHIFT +: Q_W];
      front_d[i].month    = month[i];
      front_d[i].day      = day[i];
      front_d[i].year_ok  = (year[i] != '0) && (32'(year[i]) <= 32'(MAX_YEAR));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (vld_i) begin
      front_q <= front_d;
    end
  end

  assign vld_o   = vld_q;
  assign front_o = front_q;

endmodule

@@ rtl/gdb_day_count.sv @@
`timescale 1ns / 1ps
// Second stage: leap test, date validity and the closed-form day number of both dates.
module gdb_day_count (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   vld_i,
  input  gdb_pkg::front_t [1:0]  front_i,
  output logic                   vld_o,
  output gdb_pkg::dcount_t [1:0] dcount_o
);
  import gdb_pkg::*;

  dcount_t [1:0] dcount_d;
  dcount_t [1:0] dcount_q;
  logic          vld_q;

  always_comb begin
    for (int i = 0; i < 2; i++) begin
      logic [YEAR_W-1:0] whole_cent;
      logic              leap;
      logic [MLEN_W-1:0] mlen;
      logic              late_leap;
      whole_cent = YEAR_W'(front_i[i].qyear100) * YEAR_W'(CENTURY);
      // Divisible by 4 and either not by 100, or by 400 as well.
      leap = (front_i[i].year[1:0] == 2'b00) &&
             ((whole_cent != front_i[i].year) || (front_i[i].qyear100[1:0] == 2'b00));
      mlen = month_length(front_i[i].month, leap);
      late_leap = leap && (front_i[i].month > MONTH_FEB);
      dcount_d[i].ok = front_i[i].year_ok && (mlen != '0) &&
                       (front_i[i].day != '0) && (MLEN_W'(front_i[i].day) <= mlen);
      dcount_d[i].dnum = front_i[i].yprev365
                       + DNUM_W'(front_i[i].yprev >> 2)
                       - DNUM_W'(front_i[i].qprev100)
                       + DNUM_W'(front_i[i].qprev100 >> 2)
                       + DNUM_W'(days_before_month(front_i[i].month))
                       + DNUM_W'(late_leap)
                       + DNUM_W'(front_i[i].day);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (vld_i) begin
      dcount_q <= dcount_d;
    end
  end

  assign vld_o    = vld_q;
  assign dcount_o = dcount_q;

endmodule

@@ rtl/gdb_diff.sv @@
`timescale 1ns / 1ps
// Third stage: absolute difference of the day numbers, saturation and result register.
module gdb_diff (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   vld_i,
  input  gdb_pkg::dcount_t [1:0] dcount_i,
  output logic                   vld_o,
  output gdb_pkg::res_t          res_o
);
  import gdb_pkg::*;

  logic [DNUM_W-1:0] diff;
  res_t              res_d;
  res_t              res_q;
  logic              vld_q;

  always_comb begin
    if (dcount_i[0].dnum >= dcount_i[1].dnum) begin
      diff = dcount_i[0].dnum - dcount_i[1].dnum;
    end else begin
      diff = dcount_i[1].dnum - dcount_i[0].dnum;
    end
    res_d.both_valid = dcount_i[0].ok && dcount_i[1].ok;
    if (!res_d.both_valid) begin
      res_d.days_apart = '0;
    end else if (diff > DNUM_W'(DAYS_MAX)) begin
      res_d.days_apart = DAYS_MAX;
    end else begin
      res_d.days_apart = diff[DAYS_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (vld_i) begin
      res_q <= res_d;
    end
  end

  assign vld_o = vld_q;
  assign res_o = res_q;

endmodule

@@ rtl/gregorian_days_between_top.sv @@
`timescale 1ns / 1ps
// A request accepted at a clock edge gives its result, with done_o high, once it has
// passed the three register stages of the pipe. Throughput: one request per cycle; busy_o
// is always low and the result side has no stall, so nothing ever waits.
// Reset (rst_ni low, asynchronous) clears the valid bits of every stage; payload
// registers keep whatever they held, and no result is signalled after reset until new
// requests arrive.
module gregorian_days_between_top #(
  parameter int unsigned MAX_YEAR = gdb_pkg::DEFAULT_MAX_YEAR
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  output logic          busy_o,
  input  gdb_pkg::req_t req_i,
  output logic          done_o,
  output gdb_pkg::res_t res_o
);
  import gdb_pkg::*;

  // The pipe never stalls, so a request is taken whenever start_i is high.
  logic          req_accept;
  logic          front_vld;
  front_t [1:0]  front;
  logic          count_vld;
  dcount_t [1:0] dcount;

  assign busy_o     = 1'b0;
  assign req_accept = start_i && !busy_o;

  // Stage one splits each year into the parts of the closed-form day number:
  // the previous year times 365, and the previous year and the year divided by
  // one hundred through a reciprocal multiplication.
  gdb_front #(
    .MAX_YEAR (MAX_YEAR)
  ) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .vld_i   (req_accept),
    .req_i   (req_i),
    .vld_o   (front_vld),
    .front_o (front)
  );

  // Stage two decides leap years and validity, and sums the day numbers.
  gdb_day_count u_day_count (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .vld_i    (front_vld),
    .front_i  (front),
    .vld_o    (count_vld),
    .dcount_o (dcount)
  );

  // Stage three takes the absolute difference and forms the result.
  gdb_diff u_diff (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .vld_i    (count_vld),
    .dcount_i (dcount),
    .vld_o    (done_o),
    .res_o    (res_o)
  );

`ifndef SYNTH
  // Every accepted request comes out with done_o high after the three register stages.
  a_latency : assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_accept |-> ##3 done_o)
    else $error("request did not complete after three cycles");

  // No result appears without a matching accepted request.
  a_no_spurious : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$past(req_accept, 3) |-> !done_o)
    else $error("result without a matching request");

  // An invalid date pair always reports zero days.
  a_invalid_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !res_o.both_valid) |-> (res_o.days_apart == '0))
    else $error("invalid dates with nonzero day count");
`endif

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for the Gregorian day-distance block: random and edge-case date pairs.
module testbench;
  import gdb_pkg::*;

  localparam int unsigned CLK_PERIOD    = 10;
  localparam int unsigned RESET_CYCLES  = 3;
  localparam int unsigned MAX_YEAR      = DEFAULT_MAX_YEAR;
  // After the last result the bench waits on so that any stray result can show up before
  // the verdict.
  localparam int unsigned SETTLE_CYCLES = 8;
  // Longest correct quiet stretch is the largest sender gap plus a pipe drain.
  localparam int unsigned QUIET_LIMIT   = 500;
  localparam int unsigned RANDOM_PAIRS  = 1600;

  // One calendar date in the block's own field widths.
  typedef struct packed {
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]   day;
  } date_t;

  // A request waiting to be sent, with the idle cycles that go before it. When drain is set
  // the sender also holds the request back until every earlier result has come out.
  typedef struct {
    req_t        pair;
    int unsigned gap;
    bit          drain;
  } pending_t;

  logic clk_i   = 1'b0;
  logic rst_ni  = 1'b0;
  logic start_i = 1'b0;
  req_t req_i   = '0;
  logic busy_o;
  logic done_o;
  res_t res_o;

  pending_t    date_pairs_to_send[$];
  res_t        expected_spans[$];
  bit          req_taken    = 1'b0;
  int unsigned idle_cycles  = 0;
  int unsigned quiet_cycles = 0;
  int unsigned errors       = 0;

  gregorian_days_between_top #(
    .MAX_YEAR(MAX_YEAR)
  ) DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_i),
    .busy_o (busy_o),
    .req_i  (req_i),
    .done_o (done_o),
    .res_o  (res_o)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // ---------------------------------------------------------------------------------------
  // Calendar arithmetic of the predictor.
  // ---------------------------------------------------------------------------------------

  // Gregorian rule: every fourth year is a leap year, except whole centuries that are not
  // a multiple of four hundred.
  function automatic bit is_leap(input int unsigned y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  // Days in month m of year y. A month code that names no month has no days, which makes
  // every day number in it invalid.
  function automatic int unsigned month_len(input int unsigned m, input int unsigned y);
    case (m)
      MONTH_FEB: return is_leap(y) ? 29 : 28;
      MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: return 30;
      MONTH_JAN, MONTH_MAR, MONTH_MAY, MONTH_JUL,
      MONTH_AUG, MONTH_OCT, MONTH_DEC: return 31;
      default: return 0;
    endcase
  endfunction

  function automatic bit valid_date(input date_t d);
    return 32'(d.year) >= 1 && 32'(d.year) <= MAX_YEAR &&
           32'(d.day) >= 1 && 32'(d.day) <= month_len(32'(d.month), 32'(d.year));
  endfunction

  // Day count from 1-01-01 (day 1). The months before the given one are summed one by one,
  // so February of a leap year brings its extra day in on its own.
  function automatic longint unsigned day_index(input date_t d);
    longint unsigned past;
    longint unsigned n;
    past = 64'(d.year) - 1;
    n = 365 * past + past / 4 - past / 100 + past / 400 + 64'(d.day);
    for (int unsigned k = 32'(MONTH_JAN); k < 32'(d.month); k++) begin
      n += 64'(month_len(k, 32'(d.year)));
    end
    return n;
  endfunction

  // Expected answer for one request: the absolute distance when both dates are real
  // dates, and zero with the valid flag low otherwise.
  function automatic res_t predict_span(input req_t r);
    date_t           a;
    date_t           b;
    longint unsigned na;
    longint unsigned nb;
    longint unsigned span;
    res_t            res;
    a = {r.first_year, r.first_month, r.first_day};
    b = {r.second_year, r.second_month, r.second_day};
    res = '0;
    if (valid_date(a) && valid_date(b)) begin
      na = day_index(a);
      nb = day_index(b);
      span = (na > nb) ? na - nb : nb - na;
      // Only reachable with a larger year limit, but the output saturates then.
      if (span > 64'(DAYS_MAX)) begin
        span = 64'(DAYS_MAX);
      end
      res.days_apart = span[DAYS_W-1:0];
      res.both_valid = 1'b1;
    end
    return res;
  endfunction

  // ---------------------------------------------------------------------------------------
  // Stimulus helpers.
  // ---------------------------------------------------------------------------------------

  function automatic req_t make_pair(input int unsigned y1, input int unsigned m1,
                                     input int unsigned d1, input int unsigned y2,
                                     input int unsigned m2, input int unsigned d2);
    req_t r;
    r.first_year   = y1[YEAR_W-1:0];
    r.first_month  = m1[MONTH_W-1:0];
    r.first_day    = d1[DAY_W-1:0];
    r.second_year  = y2[YEAR_W-1:0];
    r.second_month = m2[MONTH_W-1:0];
    r.second_day   = d2[DAY_W-1:0];
    return r;
  endfunction

  task automatic queue_pair(input req_t pair, input int unsigned gap, input bit drain);
    pending_t p;
    p.pair  = pair;
    p.gap   = gap;
    p.drain = drain;
    date_pairs_to_send.push_back(p);
  endtask

  // A real date, leaning on the years where the calendar rules bite: the first and last
  // years, whole centuries and multiples of four hundred. A quarter of the days are the
  // last day of their month.
  function automatic date_t random_valid_date();
    date_t       d;
    int unsigned len;
    case ($urandom_range(0, 9))
      0:       d.year = YEAR_W'($urandom_range(1, 3));
      1:       d.year = YEAR_W'($urandom_range(MAX_YEAR - 2, MAX_YEAR));
      2:       d.year = YEAR_W'($urandom_range(1, MAX_YEAR / 100) * 100);
      3:       d.year = YEAR_W'($urandom_range(1, MAX_YEAR / 400) * 400);
      default: d.year = YEAR_W'($urandom_range(1, MAX_YEAR));
    endcase
    d.month = MONTH_W'($urandom_range(32'(MONTH_JAN), 32'(MONTH_DEC)));
    len = month_len(32'(d.month), 32'(d.year));
    d.day = DAY_W'(($urandom_range(0, 3) == 0) ? len : $urandom_range(1, len));
    return d;
  endfunction

  // A date that is mostly off by one field outside its legal range, and otherwise pure
  // random bits over the full field widths (which may land on a real date now and then).
  function automatic date_t random_bad_date();
    date_t       d;
    int unsigned len;
    d = random_valid_date();
    len = month_len(32'(d.month), 32'(d.year));
    case ($urandom_range(0, 5))
      0: d.year = '0;
      1: d.year = YEAR_W'($urandom_range(MAX_YEAR + 1, (1 << YEAR_W) - 1));
      2: d.month = $urandom_range(0, 1) ? '0 :
                   MONTH_W'($urandom_range(32'(MONTH_DEC) + 1, (1 << MONTH_W) - 1));
      3: d.day = DAY_W'((len < 31 && $urandom_range(0, 1)) ? $urandom_range(len + 1, 31) : 0);
      default: begin
        d.year  = YEAR_W'($urandom_range(0, (1 << YEAR_W) - 1));
        d.month = MONTH_W'($urandom_range(0, (1 << MONTH_W) - 1));
        d.day   = DAY_W'($urandom_range(0, (1 << DAY_W) - 1));
      end
    endcase
    return d;
  endfunction

  // ---------------------------------------------------------------------------------------
  // Request list and run control.
  // ---------------------------------------------------------------------------------------
  initial begin
    date_t       a;
    date_t       b;
    int unsigned gap;
    int unsigned pacing;

    // Directed part. The widest span, its mirror and the same date twice come first.
    queue_pair(make_pair(1, 1, 1, MAX_YEAR, 12, 31), 0, 1'b0);
    queue_pair(make_pair(MAX_YEAR, 12, 31, 1, 1, 1), 0, 1'b0);
    queue_pair(make_pair(2024, 2, 29, 2024, 2, 29), 0, 1'b0);
    queue_pair(make_pair(1, 1, 1, 1, 1, 2), 1, 1'b0);
    // Leap day rules: a multiple of four hundred, a plain century and ordinary years.
    queue_pair(make_pair(2000, 2, 29, 1900, 2, 28), 0, 1'b0);
    queue_pair(make_pair(1900, 2, 29, 2000, 1, 1), 2, 1'b0);
    queue_pair(make_pair(2100, 2, 29, 2100, 3, 1), 0, 1'b0);
    queue_pair(make_pair(2023, 2, 29, 2024, 2, 29), 0, 1'b0);
    queue_pair(make_pair(2024, 3, 1, 2023, 2, 29), 3, 1'b0);
    queue_pair(make_pair(400, 2, 29, 401, 3, 1), 0, 1'b0);
    queue_pair(make_pair(MAX_YEAR, 2, 28, MAX_YEAR, 3, 1), 0, 1'b0);
    // Years out of range: zero, one past the limit and all ones.
    queue_pair(make_pair(0, 1, 1, 1, 1, 1), 0, 1'b0);
    queue_pair(make_pair(MAX_YEAR + 1, 1, 1, MAX_YEAR, 1, 1), 0, 1'b0);
    queue_pair(make_pair(16383, 15, 31, 16383, 15, 31), 0, 1'b0);
    queue_pair(make_pair(0, 0, 0, 0, 0, 0), 4, 1'b0);
    // Month and day codes outside what the calendar allows, on either side.
    queue_pair(make_pair(2021, 0, 10, 2021, 1, 10), 0, 1'b0);
    queue_pair(make_pair(2021, 1, 10, 2021, 13, 1), 0, 1'b0);
    queue_pair(make_pair(2021, 15, 1, 2021, 6, 15), 0, 1'b0);
    queue_pair(make_pair(2021, 4, 31, 2021, 5, 1), 0, 1'b0);
    queue_pair(make_pair(2021, 1, 0, 2021, 1, 1), 0, 1'b0);
    // Last days of the year and a request that waits for the pipe to empty.
    queue_pair(make_pair(2021, 1, 31, 2021, 12, 31), 0, 1'b1);
    queue_pair(make_pair(1600, 12, 31, 1601, 1, 1), 0, 1'b0);

    // Random part. The pacing style changes every 50 requests so that back-to-back bursts
    // and scattered gaps both occur; every 200th request waits for the pipe to drain.
    pacing = 0;
    for (int unsigned i = 0; i < RANDOM_PAIRS; i++) begin
      if (i % 50 == 0) begin
        pacing = $urandom_range(0, 2);
      end
      case (pacing)
        0:       gap = 0;
        1:       gap = $urandom_range(0, 15);
        default: gap = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 15) : 0;
      endcase
      a = random_valid_date();
      b = random_valid_date();
      case ($urandom_range(0, 19))
        0, 1: a = random_bad_date();
        2, 3: b = random_bad_date();
        4: begin
          a = random_bad_date();
          b = random_bad_date();
        end
        5: b = a;
        default: ;
      endcase
      queue_pair(make_pair(32'(a.year), 32'(a.month), 32'(a.day),
                           32'(b.year), 32'(b.month), 32'(b.day)), gap,
                 i % 200 == 199);
    end

    // Reset is released on a falling edge so that the driver sees it at its next falling edge.
    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Everything sent and every result back; the watchdog covers a hang here.
    while (date_pairs_to_send.size() != 0 || expected_spans.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (errors == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------------------
  // Driver. Works on the falling edge so that inputs are stable around every rising edge.
  // A request stays on the bus until a rising edge takes it; the next one goes out once its
  // idle gap has elapsed. start_i gets exactly one assignment per edge, so a request that
  // follows another without a gap keeps start_i high throughout.
  // ---------------------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      start_i <= 1'b0;
    end else begin
      if (req_taken) begin
        void'(date_pairs_to_send.pop_front());
        idle_cycles = 0;
      end else if (!start_i) begin
        idle_cycles++;
      end
      if (date_pairs_to_send.size() != 0 && idle_cycles >= date_pairs_to_send[0].gap &&
          !(date_pairs_to_send[0].drain && expected_spans.size() != 0)) begin
        start_i <= 1'b1;
        req_i   <= date_pairs_to_send[0].pair;
      end else begin
        start_i <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------------------
  // Monitor and scoreboard on the rising edge. A result is checked before the request taken
  // at the same edge is predicted, so a result can never be matched against a request that
  // arrives together with it. The watchdog counts edges at which nothing moves.
  // ---------------------------------------------------------------------------------------
  always @(posedge clk_i) begin
    res_t want;
    if (rst_ni) begin
      if (done_o) begin
        if (expected_spans.size() == 0) begin
          $display("%0t: result with no request pending: days_apart %0d, both_valid %0b",
                   $time, res_o.days_apart, res_o.both_valid);
          errors++;
        end else begin
          want = expected_spans.pop_front();
          if (res_o.days_apart !== want.days_apart) begin
            $display("%0t: days_apart expected %0d, actual %0d",
                     $time, want.days_apart, res_o.days_apart);
            errors++;
          end
          if (res_o.both_valid !== want.both_valid) begin
            $display("%0t: both_valid expected %0b, actual %0b",
                     $time, want.both_valid, res_o.both_valid);
            errors++;
          end
        end
      end
      if (start_i && !busy_o) begin
        expected_spans.push_back(predict_span(req_i));
      end
      req_taken <= start_i && !busy_o;

      if (done_o || (start_i && !busy_o)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("%0t: no progress for %0d cycles", $time, QUIET_LIMIT);
        $display("testbench: errors");
        $finish;
      end
    end
  end

endmodule
